// File: rtl/core/drct_pkg.sv
// shared types and constants of the delayed relay countdown timer
`default_nettype none

package drct_pkg;

	localparam int unsigned KNOB_W   = 16;
	localparam int unsigned VAL_W    = 8;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned MINUTE_W = 20;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 20;

	typedef enum logic [2:0] {
		MODE_IDLE      = 3'd0,
		MODE_SET_TIME  = 3'd1,
		MODE_SET_DELAY = 3'd2,
		MODE_DELAY     = 3'd3,
		MODE_RUN       = 3'd4
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REFRESH_PERIOD = 3'd0,
		REG_SECOND_TICKS   = 3'd1,
		REG_MINUTE_TICKS   = 3'd2,
		REG_SETTING_MIN    = 3'd3,
		REG_SETTING_MAX    = 3'd4
	} cfg_idx_t;

	localparam logic [PERIOD_W-1:0] REFRESH_RESET = 16'd250;
	localparam logic [PERIOD_W-1:0] SECOND_RESET  = 16'd1000;
	localparam logic [MINUTE_W-1:0] MINUTE_RESET  = 20'd60000;
	localparam logic [VAL_W-1:0]    SET_MIN_RESET = 8'd1;
	localparam logic [VAL_W-1:0]    SET_MAX_RESET = 8'd99;
	localparam logic [VAL_W-1:0]    MINUTES_RESET = 8'd5;
	localparam logic [VAL_W-1:0]    SECONDS_RESET = 8'd10;

	typedef struct packed {
		logic [PERIOD_W-1:0] refresh_period;
		logic [PERIOD_W-1:0] second_ticks;
		logic [MINUTE_W-1:0] minute_ticks;
		logic [VAL_W-1:0]    setting_min;
		logic [VAL_W-1:0]    setting_max;
	} cfg_t;

	// control state that does not depend on the tick width
	typedef struct packed {
		mode_t             mode;
		logic [KNOB_W-1:0] last_knob;
		logic [VAL_W-1:0]  minutes;
		logic [VAL_W-1:0]  seconds;
		logic [VAL_W-1:0]  remaining;
		logic              relay;
	} ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/drct_if.sv
// request channels of the delayed relay countdown timer
`default_nettype none

interface drct_poll_if import drct_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [31:0]       now_tick;
	logic [KNOB_W-1:0] knob_count;
	logic              button_pressed;

	modport source (output valid, now_tick, knob_count, button_pressed, input ready);
	modport sink (input valid, now_tick, knob_count, button_pressed, output ready);
endinterface

interface drct_res_if import drct_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             poll_taken;
	logic [2:0]       mode;
	logic             relay_on;
	logic [VAL_W-1:0] run_minutes;
	logic [VAL_W-1:0] delay_seconds;
	logic [VAL_W-1:0] count_left;

	modport source (output valid, poll_taken, mode, relay_on, run_minutes, delay_seconds,
		count_left, input ready);
	modport sink (input valid, poll_taken, mode, relay_on, run_minutes, delay_seconds,
		count_left, output ready);
endinterface

interface drct_cfg_if import drct_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/drct_step.sv
// next-state logic for one poll of the countdown timer
`default_nettype none

module drct_step import drct_pkg::*; #(
	parameter int unsigned TICK_BITS = 32
) (
	input  wire cfg_t                 cfg,
	input  wire ctl_t                 st,
	input  wire logic [TICK_BITS-1:0] last_poll,
	input  wire logic [TICK_BITS-1:0] last_step,
	input  wire logic [31:0]          now_tick,
	input  wire logic [KNOB_W-1:0]    knob,
	input  wire logic                 pressed,
	output ctl_t                      st_nxt,
	output logic [TICK_BITS-1:0]      last_poll_nxt,
	output logic [TICK_BITS-1:0]      last_step_nxt,
	output logic                      taken
);

	localparam int unsigned CMP_W = (TICK_BITS > MINUTE_W) ? TICK_BITS : MINUTE_W;

	logic [TICK_BITS-1:0] now_t;
	logic [TICK_BITS-1:0] poll_gap;
	logic [TICK_BITS-1:0] step_gap;
	logic                 sec_due;
	logic                 min_due;
	logic                 knob_moved;
	logic [VAL_W-1:0]     adj_base;
	logic [VAL_W-1:0]     adj_sum;
	logic [VAL_W-1:0]     adj_lo;
	logic [VAL_W-1:0]     adj_val;
	logic [VAL_W-1:0]     rem_dec;

	assign now_t    = TICK_BITS'(now_tick);
	assign poll_gap = now_t - last_poll;
	assign step_gap = now_t - last_step;
	assign taken    = CMP_W'(poll_gap) >= CMP_W'(cfg.refresh_period);
	assign sec_due  = CMP_W'(step_gap) >= CMP_W'(cfg.second_ticks);
	assign min_due  = CMP_W'(step_gap) >= CMP_W'(cfg.minute_ticks);

	// only the low byte of the encoder movement survives the 8-bit wrap
	assign knob_moved = knob != st.last_knob;
	assign adj_base   = (st.mode == MODE_SET_TIME) ? st.minutes : st.seconds;
	assign adj_sum    = adj_base + knob[VAL_W-1:0] - st.last_knob[VAL_W-1:0];
	assign adj_lo     = (adj_sum < cfg.setting_min) ? cfg.setting_min : adj_sum;
	assign adj_val    = (adj_lo > cfg.setting_max) ? cfg.setting_max : adj_lo;
	assign rem_dec    = st.remaining - VAL_W'(1);

	always_comb begin
		st_nxt        = st;
		last_poll_nxt = last_poll;
		last_step_nxt = last_step;
		if (taken) begin
			last_poll_nxt = now_t;
			case (st.mode)
				MODE_IDLE: begin
					st_nxt.relay     = 1'b0;
					st_nxt.last_knob = knob;
					st_nxt.mode      = MODE_SET_TIME;
				end
				MODE_SET_TIME: begin
					if (pressed) begin
						st_nxt.mode = MODE_SET_DELAY;
					end else if (knob_moved) begin
						st_nxt.minutes   = adj_val;
						st_nxt.last_knob = knob;
					end
				end
				MODE_SET_DELAY: begin
					if (pressed) begin
						last_step_nxt    = now_t;
						st_nxt.remaining = st.seconds;
						st_nxt.mode      = MODE_DELAY;
					end else if (knob_moved) begin
						st_nxt.seconds   = adj_val;
						st_nxt.last_knob = knob;
					end
				end
				MODE_DELAY: begin
					if (pressed) begin
						st_nxt.mode = MODE_IDLE;
					end else if (sec_due) begin
						last_step_nxt    = now_t;
						st_nxt.remaining = rem_dec;
						if (rem_dec == '0) begin
							st_nxt.relay     = 1'b1;
							st_nxt.remaining = st.minutes;
							st_nxt.mode      = MODE_RUN;
						end
					end
				end
				MODE_RUN: begin
					if (pressed) begin
						st_nxt.mode = MODE_IDLE;
					end else if (min_due) begin
						last_step_nxt    = now_t;
						st_nxt.remaining = rem_dec;
						if (rem_dec == '0) begin
							st_nxt.mode = MODE_IDLE;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/delayed_relay_countdown_timer.sv
// top level of the delayed relay countdown timer
//
//  channel  dir  contents
//  poll     in   now_tick, knob_count, button_pressed
//  res      out  poll_taken, mode, relay_on, run_minutes, delay_seconds, count_left
//  cfg      in   index, data (register write, always ready)
//
// one poll request per clock unless a result stalls; a poll waits in the input
// register and its result is written to the state and result registers on advance.
// the state update is one compare-and-select pass fed by the input register.
// reset clears state to idle with default settings; no clearing pass is needed.
// a stalled result holds the input register, which then lowers poll.ready.
`default_nettype none

module delayed_relay_countdown_timer import drct_pkg::*; #(
	parameter int unsigned TICK_BITS = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	drct_cfg_if.sink    cfg,
	drct_poll_if.sink   poll,
	drct_res_if.source  res
);

	cfg_t                 cfg_q;
	ctl_t                 st_q;
	ctl_t                 st_nxt;
	logic [TICK_BITS-1:0] last_poll_q;
	logic [TICK_BITS-1:0] last_step_q;
	logic [TICK_BITS-1:0] last_poll_nxt;
	logic [TICK_BITS-1:0] last_step_nxt;
	logic                 taken;

	logic                 item_valid_s1;
	logic [31:0]          now_s1;
	logic [KNOB_W-1:0]    knob_s1;
	logic                 button_s1;

	logic                 out_valid_q;
	logic                 taken_q;
	logic                 advance;

	assign advance    = item_valid_s1 && (!out_valid_q || res.ready);
	assign poll.ready = !item_valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.refresh_period <= REFRESH_RESET;
			cfg_q.second_ticks   <= SECOND_RESET;
			cfg_q.minute_ticks   <= MINUTE_RESET;
			cfg_q.setting_min    <= SET_MIN_RESET;
			cfg_q.setting_max    <= SET_MAX_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_REFRESH_PERIOD: cfg_q.refresh_period <= cfg.data[PERIOD_W-1:0];
				REG_SECOND_TICKS:   cfg_q.second_ticks   <= cfg.data[PERIOD_W-1:0];
				REG_MINUTE_TICKS:   cfg_q.minute_ticks   <= cfg.data[MINUTE_W-1:0];
				REG_SETTING_MIN:    cfg_q.setting_min    <= cfg.data[VAL_W-1:0];
				REG_SETTING_MAX:    cfg_q.setting_max    <= cfg.data[VAL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			item_valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			now_s1    <= poll.now_tick;
			knob_s1   <= poll.knob_count;
			button_s1 <= poll.button_pressed;
		end
	end

	drct_step #(
		.TICK_BITS (TICK_BITS)
	) u_step (
		.cfg           (cfg_q),
		.st            (st_q),
		.last_poll     (last_poll_q),
		.last_step     (last_step_q),
		.now_tick      (now_s1),
		.knob          (knob_s1),
		.pressed       (button_s1),
		.st_nxt        (st_nxt),
		.last_poll_nxt (last_poll_nxt),
		.last_step_nxt (last_step_nxt),
		.taken         (taken)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode      <= MODE_IDLE;
			st_q.last_knob <= '0;
			st_q.minutes   <= MINUTES_RESET;
			st_q.seconds   <= SECONDS_RESET;
			st_q.remaining <= '0;
			st_q.relay     <= 1'b0;
			last_poll_q    <= '0;
			last_step_q    <= '0;
		end else if (advance) begin
			st_q        <= st_nxt;
			last_poll_q <= last_poll_nxt;
			last_step_q <= last_step_nxt;
		end
	end

	// result register: the state register doubles as the result payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			taken_q     <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			taken_q     <= taken;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.poll_taken    = taken_q;
	assign res.mode          = st_q.mode;
	assign res.relay_on      = st_q.relay;
	assign res.run_minutes   = st_q.minutes;
	assign res.delay_seconds = st_q.seconds;
	assign res.count_left    = st_q.remaining;

`ifndef NO_ASSERTIONS
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid_s1 && !advance |=> item_valid_s1)
		else $error("held poll request dropped");

	a_relay_on_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(st_q.relay) |-> st_q.mode == MODE_RUN)
		else $error("relay switched on outside run mode");

	a_skip_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !taken |=> st_q == $past(st_q) && !taken_q)
		else $error("skipped poll changed state");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> poll.ready)
		else $error("poll stalled with empty result register");
`endif

endmodule

`default_nettype wire
